// File: rtl/sha1_message_hasher_core_macros.svh
// assertion helpers for the sha-1 hasher
`ifndef SHA1_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA1_MESSAGE_HASHER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define SHA1MH_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next
`define SHA1MH_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHA1MH_ASSERT(label, clock, reset, prop, msg)
`define SHA1MH_ASSERT_NEXT(label, clock, reset, ante, cons, msg)

`endif

`endif

// File: rtl/sha1mh_pkg.sv
`timescale 1ns / 1ps

package sha1mh_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:4][31:0] hash_t;
  typedef logic [0:15][31:0] sched_t;
  typedef logic [6:0] round_t;
  typedef logic [5:0] byte_cnt_t;
  typedef logic [2:0] word_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_OUT
  } state_t;

  localparam hash_t INIT_CHAIN = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam round_t PHASE1_START = 7'd20;
  localparam round_t PHASE2_START = 7'd40;
  localparam round_t PHASE3_START = 7'd60;
  localparam round_t LAST_ROUND   = 7'd79;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam byte_cnt_t  LEN_OFFSET = 6'd56;
  localparam byte_cnt_t  BLOCK_LAST = 6'd63;
  localparam word_idx_t  LAST_INDEX = 3'd4;

endpackage

// File: rtl/sha1_message_hasher_core.sv
// channel | handshake            | payload
// input   | in_valid / in_ready  | data_byte, byte_valid, last_byte
// output  | out_valid / out_ready| digest_word, word_index, last_word
//
// a byte that neither fills a block nor is last leaves the core idle; the
// 64th byte runs 80 rounds in the single round unit, then a chaining add;
// end of message: pad and length bytes (9 to 72) go in one by one, each
// padded block (one or two) is hashed, then five digest words go out;
// in_ready is low from a full block to its add, from a last request until
// the fifth word is taken; rst (sync) restores the initial chaining value
`timescale 1ns / 1ps

module sha1_message_hasher_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                byte_valid,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output sha1mh_pkg::word_t   digest_word,
  output sha1mh_pkg::word_idx_t word_index,
  output logic                last_word
);
  import sha1mh_pkg::*;

  `include "sha1_message_hasher_core_macros.svh"

  state_t    state, state_next;
  state_t    resume, resume_next;
  round_t    round_cnt, round_cnt_next;
  byte_cnt_t byte_cnt, byte_cnt_next;
  logic [63:0] bit_cnt, bit_cnt_next;
  hash_t     chain, chain_next;
  hash_t     work, work_next;
  hash_t     round_out;
  sched_t    sched, sched_next;
  word_idx_t word_idx, word_idx_next;

  logic [511:0] sched_flat;
  word_t        w_mix;
  word_t        w_new;

  assign sched_flat = sched;
  assign w_mix      = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w_new      = {w_mix[30:0], w_mix[31]};

  sha1mh_round u_round (
    .cur (work),
    .w   (sched[0]),
    .rnd (round_cnt),
    .nxt (round_out)
  );

  assign in_ready    = (state == ST_IDLE);
  assign out_valid   = (state == ST_OUT);
  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == LAST_INDEX);

  always_comb begin
    state_next     = state;
    resume_next    = resume;
    round_cnt_next = round_cnt;
    byte_cnt_next  = byte_cnt;
    bit_cnt_next   = bit_cnt;
    chain_next     = chain;
    work_next      = work;
    sched_next     = sched;
    word_idx_next  = word_idx;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_valid) begin
            sched_next    = {sched_flat[503:0], data_byte};
            byte_cnt_next = byte_cnt + 6'd1;
            bit_cnt_next  = bit_cnt + 64'd8;
            if (byte_cnt == BLOCK_LAST) begin
              work_next      = chain;
              round_cnt_next = '0;
              state_next     = ST_ROUND;
              resume_next    = last_byte ? ST_PAD_MARK : ST_IDLE;
            end else if (last_byte) begin
              state_next = ST_PAD_MARK;
            end
          end else if (last_byte) begin
            state_next = ST_PAD_MARK;
          end
        end
      end

      ST_ROUND: begin
        work_next  = round_out;
        sched_next = {sched[1:15], w_new};
        if (round_cnt == LAST_ROUND) begin
          round_cnt_next = '0;
          state_next     = ST_ADD;
        end else begin
          round_cnt_next = round_cnt + 7'd1;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_next[i] = chain[i] + work[i];
        end
        word_idx_next = '0;
        state_next    = resume;
      end

      ST_PAD_MARK: begin
        sched_next    = {sched_flat[503:0], PAD_BYTE};
        byte_cnt_next = byte_cnt + 6'd1;
        if (byte_cnt == BLOCK_LAST) begin
          work_next      = chain;
          round_cnt_next = '0;
          state_next     = ST_ROUND;
          resume_next    = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end

      ST_PAD_ZERO: begin
        if (byte_cnt == LEN_OFFSET) begin
          state_next = ST_PAD_LEN;
        end else begin
          sched_next    = {sched_flat[503:0], 8'h00};
          byte_cnt_next = byte_cnt + 6'd1;
          if (byte_cnt == BLOCK_LAST) begin
            work_next      = chain;
            round_cnt_next = '0;
            state_next     = ST_ROUND;
            resume_next    = ST_PAD_ZERO;
          end
        end
      end

      ST_PAD_LEN: begin
        sched_next    = {sched_flat[503:0], bit_cnt[63:56]};
        bit_cnt_next  = {bit_cnt[55:0], 8'h00};
        byte_cnt_next = byte_cnt + 6'd1;
        if (byte_cnt == BLOCK_LAST) begin
          work_next      = chain;
          round_cnt_next = '0;
          state_next     = ST_ROUND;
          resume_next    = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          if (word_idx == LAST_INDEX) begin
            chain_next    = INIT_CHAIN;
            bit_cnt_next  = '0;
            word_idx_next = '0;
            state_next    = ST_IDLE;
          end else begin
            word_idx_next = word_idx + 3'd1;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      resume    <= ST_IDLE;
      round_cnt <= '0;
      byte_cnt  <= '0;
      bit_cnt   <= '0;
      chain     <= INIT_CHAIN;
      work      <= '0;
      word_idx  <= '0;
    end else begin
      state     <= state_next;
      resume    <= resume_next;
      round_cnt <= round_cnt_next;
      byte_cnt  <= byte_cnt_next;
      bit_cnt   <= bit_cnt_next;
      chain     <= chain_next;
      work      <= work_next;
      word_idx  <= word_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    sched <= sched_next;
  end

  `SHA1MH_ASSERT(a_ready_excl, clk, rst, !(in_ready && out_valid), "ready while digest pending")
  `SHA1MH_ASSERT(a_round_range, clk, rst, round_cnt <= LAST_ROUND, "round counter out of range")
  `SHA1MH_ASSERT(a_idle_round, clk, rst, !in_ready || round_cnt == 7'd0, "idle with rounds open")
  `SHA1MH_ASSERT_NEXT(a_word_step, clk, rst, out_valid && out_ready && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1, "digest word skipped")
  `SHA1MH_ASSERT_NEXT(a_done_idle, clk, rst, out_valid && out_ready && last_word,
    in_ready && bit_cnt == 64'd0, "no return to idle after digest")

endmodule

// File: rtl/sha1mh_round.sv
`timescale 1ns / 1ps

module sha1mh_round (
  input  sha1mh_pkg::hash_t  cur,
  input  sha1mh_pkg::word_t  w,
  input  sha1mh_pkg::round_t rnd,
  output sha1mh_pkg::hash_t  nxt
);
  import sha1mh_pkg::*;

  word_t f;
  word_t k;
  word_t b;
  word_t c;
  word_t d;

  assign b = cur[1];
  assign c = cur[2];
  assign d = cur[3];

  always_comb begin
    if (rnd < PHASE1_START) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < PHASE2_START) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < PHASE3_START) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  always_comb begin
    nxt[0] = {cur[0][26:0], cur[0][31:27]} + f + cur[4] + k + w;
    nxt[1] = cur[0];
    nxt[2] = {cur[1][1:0], cur[1][31:2]};
    nxt[3] = cur[2];
    nxt[4] = cur[3];
  end

endmodule

// File: verif/tb_sha1_message_hasher_core.sv
`timescale 1ns / 1ps

module tb_sha1_message_hasher_core;
  import sha1mh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned DIR_ROWS = 11;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
    bit         known;
    hash_t      digest;
  } stim_row_t;

  typedef struct {
    word_t     word;
    word_idx_t idx;
    logic      fin;
  } digest_word_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  logic [7:0] data_byte;
  logic      byte_valid;
  logic      last_byte;
  logic      out_valid;
  logic      out_ready;
  word_t     digest_word;
  word_idx_t word_index;
  logic      last_word;

  bit          rst_done;
  bit          burst_mode;
  int unsigned err_count;
  int unsigned cycle_count;

  // hasher state mirrored on the testbench side
  word_t         chain_q [0:4];
  word_t         sched_q [0:15];
  logic [5:0]    blk_fill;
  logic [63:0]   bit_len;
  digest_word_t  pending_digest_q [$];
  stim_row_t     dir_rows [DIR_ROWS];

  sha1_message_hasher_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic word_t rol32(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void pack_byte(input int pos, input logic [7:0] b);
    if (pos % 4 == 0) begin
      sched_q[pos / 4] = {b, 24'h0};
    end else begin
      sched_q[pos / 4][8 * (3 - pos % 4) +: 8] = b;
    end
  endfunction

  function automatic void sha1_block();
    word_t a, b, c, d, e, f, k, t;
    word_t w [0:15];
    w = sched_q;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) chain_q[i] = INIT_CHAIN[i];
    for (int i = 0; i < 16; i++) sched_q[i] = '0;
    blk_fill = '0;
    bit_len  = '0;
  endfunction

  // absorbs one request; on the last one queues the five digest words
  function automatic void sha1_absorb(input logic [7:0] d, input logic bv, input logic lst,
                                      input bit known, input hash_t known_digest);
    digest_word_t dw;
    if (bv) begin
      pack_byte(int'(blk_fill), d);
      bit_len  += 64'd8;
      blk_fill += 6'd1;
      if (blk_fill == 6'd0) sha1_block();
    end
    if (!lst) return;
    pack_byte(int'(blk_fill), PAD_BYTE);
    for (int p = int'(blk_fill) + 1; p < 64; p++) pack_byte(p, 8'h00);
    if (blk_fill >= LEN_OFFSET) begin
      sha1_block();
      for (int i = 0; i < 16; i++) sched_q[i] = '0;
    end
    sched_q[14] = bit_len[63:32];
    sched_q[15] = bit_len[31:0];
    sha1_block();
    for (int i = 0; i < 5; i++) begin
      dw.word = known ? known_digest[i] : chain_q[i];
      dw.idx  = word_idx_t'(i);
      dw.fin  = (word_idx_t'(i) == LAST_INDEX);
      pending_digest_q.push_back(dw);
    end
    sha1_restart();
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_request(input logic [7:0] d, input logic bv, input logic lst,
                              input bit known = 1'b0, input hash_t known_digest = '0);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    byte_valid <= bv;
    last_byte  <= lst;
    do @(posedge clk); while (!in_ready);
    sha1_absorb(d, bv, lst, known, known_digest);
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    bit sep_end;
    sep_end    = (len == 0) || ($urandom_range(0, 3) == 0);
    burst_mode = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1, !sep_end && (i == len - 1));
    end
    if (sep_end) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // digest receiver and checker
  initial begin
    int unsigned  gap;
    digest_word_t exp_w;
    out_ready = 1'b0;
    wait (rst_done);
    @(negedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_digest_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected digest word %h index %0d last %b",
                   digest_word, word_index, last_word);
      end else begin
        exp_w = pending_digest_q.pop_front();
        if (digest_word !== exp_w.word || word_index !== exp_w.idx ||
            last_word !== exp_w.fin) begin
          err_count++;
          if (err_count <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     exp_w.word, exp_w.idx, exp_w.fin, digest_word, word_index, last_word);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[sha1_message_hasher_core] ERROR");
    $finish;
  end

  initial begin
    int forced_len [2];
    int unsigned rand_bytes;
    int unsigned rand_msgs;
    int len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    byte_valid = 1'b0;
    last_byte  = 1'b0;
    sha1_restart();
    dir_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},
      // empty message
      '{8'hFF, 1'b0, 1'b1, 1'b1,
        {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709}},
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, 1'b1,
        {32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d}},
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
      // end with no byte after a partial block
      '{8'h5A, 1'b0, 1'b1, 1'b0, '0},
      '{8'hA5, 1'b1, 1'b1, 1'b0, '0},
      // chaining value must be back to its initial value
      '{8'h00, 1'b0, 1'b1, 1'b1,
        {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709}}
    };
    forced_len = '{56, 64};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst      = 1'b0;
    rst_done = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].data, dir_rows[i].valid, dir_rows[i].last,
                   dir_rows[i].known, dir_rows[i].digest);

    // padding boundaries: length spills into an extra block, full block
    foreach (forced_len[i]) send_message(forced_len[i]);

    rand_bytes = 0;
    rand_msgs  = 0;
    while (rand_bytes < 12 || rand_msgs < 3) begin
      len = $urandom_range(0, 12);
      send_message(len);
      rand_bytes += len;
      rand_msgs++;
    end
    in_valid <= 1'b0;

    while (pending_digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_digest_q.size() != 0) err_count++;

    if (err_count == 0)
      $display("[sha1_message_hasher_core] OK");
    else
      $display("[sha1_message_hasher_core] ERROR");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/sha1mh_pkg.sv
rtl/sha1mh_round.sv
rtl/sha1_message_hasher_core.sv
verif/tb_sha1_message_hasher_core.sv
